[sv/mvm_pkg.sv]
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared constants, codes and helpers of the matrix-vector multiply core.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int DEFAULT_MAX_COLUMNS = 256;
    localparam int DEFAULT_MAX_ROWS    = 256;

    localparam int ELEMENT_W = 16;
    localparam int PRODUCT_W = 32;
    localparam int SUM_W     = 48;
    localparam int COUNT_W   = 9;
    localparam int ROW_NUM_W = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [COUNT_W-1:0] ROW_COUNT_RESET    = 9'd16;
    localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET = 9'd16;

    localparam logic OP_LOAD_VECTOR    = 1'b0;
    localparam logic OP_MATRIX_ELEMENT = 1'b1;

    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // Maps a programmed count onto 1..maxv.
    function automatic logic [31:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                input int maxv);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide == 32'd0)
        begin
            return 32'd1;
        end
        if (wide > 32'(maxv))
        begin
            return 32'(maxv);
        end
        return wide;
    endfunction

endpackage

[sv/mvm_vector_store.sv]
// ----------------------------------------------------------------------------
// mvm_vector_store
// Single-port-write, single-port-read vector memory with registered read data.
// ----------------------------------------------------------------------------
module mvm_vector_store #(
    parameter int DEPTH  = mvm_pkg::DEFAULT_MAX_COLUMNS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic [mvm_pkg::ELEMENT_W-1:0]  wr_data,
    input  logic                           rd_en,
    input  logic [ADDR_W-1:0]              rd_addr,
    output logic [mvm_pkg::ELEMENT_W-1:0]  rd_data
);

    logic [mvm_pkg::ELEMENT_W-1:0] mem [DEPTH];
    logic [mvm_pkg::ELEMENT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/matrix_vector_multiply_core.sv]
// A matrix element that ends a row shows its dot product once it has passed stage 1, stage 2 and the output register.
// Throughput: one request per cycle while in_stall is low, vector loads and matrix elements alike.
// The pipeline is vector memory read, 16x16 multiply, then 48-bit accumulate into the output.
// Reset clears the counters, the accumulator, the pipeline and sets both counts to 16.
// The vector memory is not cleared; entries must be loaded before they are used.
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// Streams a vector into memory, then multiplies matrix rows against it.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core #(
    parameter int MAX_COLUMNS = mvm_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = mvm_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic signed [mvm_pkg::ELEMENT_W-1:0] element_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mvm_pkg::ROW_NUM_W-1:0]       row_number,
    output logic signed [mvm_pkg::SUM_W-1:0]    dot_product,
    output logic                                last_row,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mvm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mvm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mvm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [mvm_pkg::COUNT_W-1:0] row_count_reg;
    logic [mvm_pkg::COUNT_W-1:0] column_count_reg;
    logic                        cfg_write;

    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [ADDR_W-1:0] col_reg;
    logic [ADDR_W-1:0] col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    logic [31:0]      cols;
    logic [31:0]      rows;
    logic [CNT_W-1:0] fill_base;
    logic             accept;
    logic             is_matrix;
    logic             col_end;
    logic             row_last;

    logic             store_wr_en;
    logic             store_rd_en;
    logic [mvm_pkg::ELEMENT_W-1:0] store_rd_data;

    logic                                 s1_valid_reg;
    logic signed [mvm_pkg::ELEMENT_W-1:0] s1_value_reg;
    logic                                 s1_end_reg;
    logic                                 s1_last_reg;
    logic [mvm_pkg::ROW_NUM_W-1:0]        s1_row_reg;

    logic                                 s2_valid_reg;
    logic signed [mvm_pkg::PRODUCT_W-1:0] s2_product_reg;
    logic                                 s2_end_reg;
    logic                                 s2_last_reg;
    logic [mvm_pkg::ROW_NUM_W-1:0]        s2_row_reg;

    logic signed [mvm_pkg::SUM_W-1:0] acc_reg;
    logic signed [mvm_pkg::SUM_W-1:0] acc_sum;

    logic                             out_valid_reg;
    logic signed [mvm_pkg::SUM_W-1:0] out_sum_reg;
    logic [mvm_pkg::ROW_NUM_W-1:0]    out_row_reg;
    logic                             out_last_reg;

    logic out_ready;
    logic s2_go;
    logic s2_free;
    logic s1_go;
    logic s1_free;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= mvm_pkg::ROW_COUNT_RESET;
            column_count_reg <= mvm_pkg::COLUMN_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                mvm_pkg::REG_ROW_COUNT:    row_count_reg    <= pwdata[mvm_pkg::COUNT_W-1:0];
                mvm_pkg::REG_COLUMN_COUNT: column_count_reg <= pwdata[mvm_pkg::COUNT_W-1:0];
                default:                   row_count_reg    <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mvm_pkg::REG_ROW_COUNT:    prdata = mvm_pkg::APB_DATA_W'(row_count_reg);
            mvm_pkg::REG_COLUMN_COUNT: prdata = mvm_pkg::APB_DATA_W'(column_count_reg);
            default:                   prdata = '0;
        endcase
    end

    // Pipeline flow control.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_go     = s2_valid_reg && (!s2_end_reg || out_ready);
    assign s2_free   = !s2_valid_reg || s2_go;
    assign s1_go     = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s1_go;
    assign in_stall  = !s1_free;
    assign accept    = in_valid && !in_stall;
    assign is_matrix = (opcode == mvm_pkg::OP_MATRIX_ELEMENT);

    // Request decode and position bookkeeping.
    always_comb
    begin
        cols      = mvm_pkg::clamp_count(column_count_reg, MAX_COLUMNS);
        rows      = mvm_pkg::clamp_count(row_count_reg, MAX_ROWS);
        fill_base = (32'(fill_reg) >= cols) ? '0 : fill_reg;
        col_end   = (32'(col_reg) + 32'd1) >= cols;
        row_last  = (32'(row_reg) + 32'd1) >= rows;

        fill_next = fill_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept && !is_matrix)
        begin
            fill_next = fill_base + CNT_W'(1);
        end
        if (accept && is_matrix)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    assign store_wr_en = accept && !is_matrix;
    assign store_rd_en = accept && is_matrix;

    mvm_vector_store #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (ADDR_W)
    ) u_vector_store (
        .clk     (clk),
        .wr_en   (store_wr_en),
        .wr_addr (fill_base[ADDR_W-1:0]),
        .wr_data (element_value),
        .rd_en   (store_rd_en),
        .rd_addr (col_reg),
        .rd_data (store_rd_data)
    );

    // Stage 1: memory read in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= store_rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_rd_en)
        begin
            s1_value_reg <= element_value;
            s1_end_reg   <= col_end;
            s1_last_reg  <= row_last;
            s1_row_reg   <= mvm_pkg::ROW_NUM_W'(row_reg);
        end
    end

    // Stage 2: product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_product_reg <= s1_value_reg * $signed(store_rd_data);
            s2_end_reg     <= s1_end_reg;
            s2_last_reg    <= s1_last_reg;
            s2_row_reg     <= s1_row_reg;
        end
    end

    // Stage 3: accumulate and present the row result.
    assign acc_sum = acc_reg + {{(mvm_pkg::SUM_W - mvm_pkg::PRODUCT_W){s2_product_reg[
        mvm_pkg::PRODUCT_W-1]}}, s2_product_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_go)
            begin
                acc_reg <= s2_end_reg ? '0 : acc_sum;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_go && s2_end_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_end_reg)
        begin
            out_sum_reg  <= acc_sum;
            out_row_reg  <= s2_row_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dot_product = out_sum_reg;
    assign row_number  = out_row_reg;
    assign last_row    = out_last_reg;

endmodule

[sv/mvm_checker.sv]
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks of the matrix-vector multiply core, bound to the top level.
// ----------------------------------------------------------------------------
module mvm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [mvm_pkg::ROW_NUM_W-1:0]        row_number,
    input logic signed [mvm_pkg::SUM_W-1:0]     dot_product,
    input logic                                 last_row,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [mvm_pkg::APB_ADDR_W-1:0]       paddr,
    input logic [mvm_pkg::APB_DATA_W-1:0]       pwdata,
    input logic [mvm_pkg::APB_DATA_W-1:0]       prdata
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dot_product)
            && $stable(row_number) && $stable(last_row))
        else $error("result changed while stalled");

    // The input side only stalls while a finished result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // Reset leaves no result pending.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result pending after reset");

    // A register write reads back on the next cycle at the same address.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |=> ($past(paddr[2]) != paddr[2])
            || (prdata[mvm_pkg::COUNT_W-1:0] == $past(pwdata[mvm_pkg::COUNT_W-1:0])))
        else $error("register readback mismatch");

endmodule

bind matrix_vector_multiply_core mvm_checker u_mvm_checker (.*);

[verif/mvm_product_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mvm_product_checker
// Watches the request, result and register channels of the matrix-vector
// multiply core. It keeps its own copy of the counts, the vector and the row
// progress, works out each row's dot product when the matrix element that
// ends the row is accepted, and compares every accepted result field by
// field with the oldest expected row.
// ----------------------------------------------------------------------------
module mvm_product_checker
    import mvm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        opcode,
    input  logic signed [ELEMENT_W-1:0] element_value,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [ROW_NUM_W-1:0]        row_number,
    input  logic signed [SUM_W-1:0]     dot_product,
    input  logic                        last_row,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output int                          fail_count,
    output int                          pending_results
);

    localparam logic [APB_ADDR_W-1:0] ROW_COUNT_ADDR    = {REG_ROW_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] COLUMN_COUNT_ADDR = {REG_COLUMN_COUNT, 2'b00};

    typedef struct packed {
        logic [ROW_NUM_W-1:0]    row;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } row_result_t;

    logic signed [ELEMENT_W-1:0] vector_copy [0:DEFAULT_MAX_COLUMNS-1];
    logic [COUNT_W-1:0]          fill_index;
    logic [COUNT_W-1:0]          rows_setting;
    logic [COUNT_W-1:0]          cols_setting;
    int                          column_at;
    int                          row_at;
    logic signed [SUM_W-1:0]     partial_sum;
    row_result_t                 expected_rows [$];
    int                          mismatches = 0;

    assign fail_count = mismatches;

    function automatic int effective_count(input logic [COUNT_W-1:0] setting,
                                           input int limit);
        if (setting == '0)
        begin
            return 1;
        end
        if (int'(setting) > limit)
        begin
            return limit;
        end
        return int'(setting);
    endfunction

    task automatic predict_request(input logic op,
                                   input logic signed [ELEMENT_W-1:0] value);
        int                          cols;
        int                          rows;
        logic signed [PRODUCT_W-1:0] product;
        row_result_t                 finished;
        cols = effective_count(cols_setting, DEFAULT_MAX_COLUMNS);
        rows = effective_count(rows_setting, DEFAULT_MAX_ROWS);
        if (op == OP_LOAD_VECTOR)
        begin
            if (int'(fill_index) >= cols)
            begin
                fill_index = '0;
            end
            vector_copy[fill_index] = value;
            fill_index = fill_index + 1'b1;
        end
        else
        begin
            product = value * vector_copy[column_at];
            partial_sum = partial_sum + product;
            if (column_at + 1 >= cols)
            begin
                finished.row  = ROW_NUM_W'(row_at);
                finished.sum  = partial_sum;
                finished.last = (row_at + 1 >= rows);
                expected_rows.push_back(finished);
                partial_sum = '0;
                column_at = 0;
                row_at = finished.last ? 0 : row_at + 1;
            end
            else
            begin
                column_at = column_at + 1;
            end
        end
    endtask

    task automatic check_row_result();
        row_result_t want;
        if (expected_rows.size() == 0)
        begin
            $display("%0t: unexpected result, row_number %0d dot_product %0d last_row %0d",
                     $time, row_number, dot_product, last_row);
            mismatches++;
        end
        else
        begin
            want = expected_rows.pop_front();
            if (row_number !== want.row)
            begin
                $display("%0t: row_number expected %0d actual %0d",
                         $time, want.row, row_number);
                mismatches++;
            end
            if (dot_product !== want.sum)
            begin
                $display("%0t: dot_product of row %0d expected %0d actual %0d",
                         $time, want.row, want.sum, dot_product);
                mismatches++;
            end
            if (last_row !== want.last)
            begin
                $display("%0t: last_row of row %0d expected %0d actual %0d",
                         $time, want.row, want.last, last_row);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_index   = '0;
            column_at    = 0;
            row_at       = 0;
            partial_sum  = '0;
            rows_setting = ROW_COUNT_RESET;
            cols_setting = COLUMN_COUNT_RESET;
            expected_rows.delete();
            pending_results <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ROW_COUNT_ADDR)
                begin
                    rows_setting = pwdata[COUNT_W-1:0];
                end
                else if (paddr == COLUMN_COUNT_ADDR)
                begin
                    cols_setting = pwdata[COUNT_W-1:0];
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_request(opcode, element_value);
            end
            if (out_valid && !out_stall)
            begin
                check_row_result();
            end
            pending_results <= expected_rows.size();
        end
    end

endmodule

[verif/tb_matrix_vector_multiply_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_multiply_core
// Drives vector loads, matrix elements and count writes into the core, with
// random gaps on the request side and random stalls on the result side.
// A short directed part covers value extremes, out-of-range counts, vector
// reloads in the middle of a product and counts shrunk mid-row and
// mid-product; random products of mostly small sizes and two of the largest
// sizes follow. The checker beside the core judges every result.
// ----------------------------------------------------------------------------
module tb_matrix_vector_multiply_core;
    import mvm_pkg::*;

    localparam int CLOCK_PERIOD     = 20;
    localparam int RESET_CYCLES     = 5;
    localparam int DRAIN_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int RANDOM_ITEMS     = 600;

    localparam logic [APB_ADDR_W-1:0] ROW_COUNT_ADDR    = {REG_ROW_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] COLUMN_COUNT_ADDR = {REG_COLUMN_COUNT, 2'b00};

    localparam logic signed [ELEMENT_W-1:0] MOST_NEGATIVE = 16'sh8000;
    localparam logic signed [ELEMENT_W-1:0] MOST_POSITIVE = 16'sh7fff;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        opcode = OP_LOAD_VECTOR;
    logic signed [ELEMENT_W-1:0] element_value = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [ROW_NUM_W-1:0]        row_number;
    logic signed [SUM_W-1:0]     dot_product;
    logic                        last_row;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]       paddr = '0;
    logic [APB_DATA_W-1:0]       pwdata = '0;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;
    int                          fail_count;
    int                          pending_results;

    bit vector_written [0:DEFAULT_MAX_COLUMNS-1];
    int fill_next = 0;
    int column_next = 0;
    int columns_active = 16;
    int rows_active = 16;
    int items_sent = 0;
    bit burst_mode = 1'b0;
    bit long_hold_due = 1'b0;
    bit quiet_stretch = 1'b0;

    matrix_vector_multiply_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_number    (row_number),
        .dot_product   (dot_product),
        .last_row      (last_row),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mvm_product_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .element_value   (element_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .row_number      (row_number),
        .dot_product     (dot_product),
        .last_row        (last_row),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        forever #(CLOCK_PERIOD / 2) clk = ~clk;
    end

    function automatic int pause_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic signed [ELEMENT_W-1:0] random_element();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return MOST_NEGATIVE;
        end
        if (pick == 1)
        begin
            return MOST_POSITIVE;
        end
        return ELEMENT_W'($urandom);
    endfunction

    function automatic int count_in_effect(input int setting, input int limit);
        int masked;
        masked = setting % (1 << COUNT_W);
        return (masked == 0) ? 1 : ((masked > limit) ? limit : masked);
    endfunction

    function automatic int random_small_count();
        return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    endfunction

    task automatic send_request(input logic op, input logic signed [ELEMENT_W-1:0] value);
        int gap;
        gap = (burst_mode || $urandom_range(0, 1) == 0) ? 0 : pause_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        element_value <= value;
        do @(posedge clk); while (in_stall);
        if (op == OP_LOAD_VECTOR)
        begin
            if (fill_next >= columns_active)
            begin
                fill_next = 0;
            end
            vector_written[fill_next] = 1'b1;
            fill_next++;
        end
        else
        begin
            column_next = (column_next + 1 >= columns_active) ? 0 : column_next + 1;
        end
        items_sent++;
    endtask

    // A matrix element is only offered when its vector entry has been loaded.
    task automatic send_matrix_element();
        if (vector_written[column_next])
        begin
            send_request(OP_MATRIX_ELEMENT, random_element());
        end
        else
        begin
            send_request(OP_LOAD_VECTOR, random_element());
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr, input int data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= APB_DATA_W'(data);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (addr == COLUMN_COUNT_ADDR)
        begin
            columns_active = count_in_effect(data, DEFAULT_MAX_COLUMNS);
        end
        else
        begin
            rows_active = count_in_effect(data, DEFAULT_MAX_ROWS);
        end
    endtask

    task automatic set_counts(input int rows_value, input int cols_value,
                              input bit write_rows, input bit write_cols);
        wait_idle();
        if (write_rows)
        begin
            write_register(ROW_COUNT_ADDR, rows_value);
        end
        if (write_cols)
        begin
            write_register(COLUMN_COUNT_ADDR, cols_value);
        end
    endtask

    task automatic run_product(input int rows_value, input int cols_value,
                               input bit write_rows, input bit write_cols,
                               input bit hold_results);
        set_counts(rows_value, cols_value, write_rows, write_cols);
        burst_mode = hold_results || ($urandom_range(0, 3) == 0);
        if (hold_results)
        begin
            long_hold_due = 1'b1;
        end
        repeat (columns_active) send_request(OP_LOAD_VECTOR, random_element());
        repeat (rows_active * columns_active)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                send_request(OP_LOAD_VECTOR, random_element());
            end
            send_matrix_element();
        end
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 10))
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_matrix_element();
                end
                else
                begin
                    send_request(OP_LOAD_VECTOR, random_element());
                end
            end
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        int  span;
        logic hold_value;
        forever
        begin
            if (long_hold_due)
            begin
                hold_value = 1'b1;
                span = LONG_HOLD_CYCLES;
                long_hold_due = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    quiet_stretch = !quiet_stretch;
                end
                hold_value = !quiet_stretch && ($urandom_range(0, 2) == 0);
                span = pause_span();
            end
            out_stall <= hold_value;
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int random_start;
        bit tall_done;
        bit wide_done;
        tall_done = 1'b0;
        wide_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Zero counts act as one: every matrix element is a whole product.
        set_counts(0, 0, 1'b1, 1'b1);
        send_request(OP_LOAD_VECTOR, MOST_NEGATIVE);
        send_request(OP_MATRIX_ELEMENT, MOST_NEGATIVE);
        send_request(OP_MATRIX_ELEMENT, MOST_POSITIVE);
        send_request(OP_LOAD_VECTOR, MOST_POSITIVE);
        send_request(OP_MATRIX_ELEMENT, MOST_NEGATIVE);
        send_request(OP_LOAD_VECTOR, 16'sd0);
        send_request(OP_MATRIX_ELEMENT, MOST_POSITIVE);

        // Vector reload in the middle of a row, then the row count shrinks
        // below the current row.
        set_counts(256, 2, 1'b1, 1'b1);
        send_request(OP_LOAD_VECTOR, MOST_POSITIVE);
        send_request(OP_LOAD_VECTOR, -16'sd1);
        send_request(OP_MATRIX_ELEMENT, 16'sd1);
        send_request(OP_MATRIX_ELEMENT, MOST_NEGATIVE);
        send_request(OP_MATRIX_ELEMENT, MOST_POSITIVE);
        send_request(OP_LOAD_VECTOR, 16'sd5);
        send_request(OP_MATRIX_ELEMENT, MOST_POSITIVE);
        send_request(OP_MATRIX_ELEMENT, -16'sd1);
        send_request(OP_MATRIX_ELEMENT, 16'sd0);
        set_counts(2, 0, 1'b1, 1'b0);
        send_request(OP_MATRIX_ELEMENT, 16'sd3);
        send_request(OP_MATRIX_ELEMENT, 16'sd4);

        // The column count shrinks below the current column mid-row.
        set_counts(1, 256, 1'b1, 1'b1);
        send_request(OP_LOAD_VECTOR, MOST_NEGATIVE);
        send_request(OP_LOAD_VECTOR, 16'sh1234);
        send_request(OP_LOAD_VECTOR, MOST_POSITIVE);
        send_request(OP_MATRIX_ELEMENT, MOST_NEGATIVE);
        send_request(OP_MATRIX_ELEMENT, MOST_POSITIVE);
        set_counts(0, 2, 1'b0, 1'b1);
        send_request(OP_MATRIX_ELEMENT, -16'sd1);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (!tall_done && items_sent - random_start >= 100)
            begin
                run_product($urandom_range(256, 511), 1, 1'b1, 1'b1, 1'b1);
                tall_done = 1'b1;
            end
            else if (!wide_done && items_sent - random_start >= 350)
            begin
                run_product($urandom_range(0, 1), $urandom_range(256, 511), 1'b1, 1'b1, 1'b0);
                wide_done = 1'b1;
            end
            else
            begin
                run_product(random_small_count(), random_small_count(),
                            $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, 1'b0);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_results == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
